/* src/fourier_series_synthesizer_defines.svh */
// assertion macros shared by the synthesizer modules
`ifndef FOURIER_SERIES_SYNTHESIZER_DEFINES_SVH
`define FOURIER_SERIES_SYNTHESIZER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk_i, off during reset
`define FSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSS_ASSERT_IMP(lbl, ante, cons, msg)
`define FSS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* src/fss_pkg.sv */
package fss_pkg;

  localparam int MAX_HARMONIC = 15;
  localparam int POINTS       = 1024;

  localparam int STORE_DEPTH = 2 * MAX_HARMONIC + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int PHASE_W     = $clog2(POINTS);
  localparam int ROM_DEPTH   = POINTS / 2 + 1;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);

  localparam int COEF_W = 16;
  localparam int TRIG_W = 16;
  localparam int CNT_W  = 4;
  localparam int HARM_W = 5;
  localparam int T_W    = 11;
  localparam int OUT_W  = 32;
  localparam int PROD_W = COEF_W + TRIG_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(STORE_DEPTH);

  localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
  localparam int TAYLOR_TERMS = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic issue;
    logic fin;
  } ctl_t;

  typedef logic [ROM_DEPTH-1:0][2*TRIG_W-1:0] rom_t;

  // cos/sin of 2*pi*p/POINTS in q1.14, {cos, sin}, via q28 taylor series
  function automatic logic [2*TRIG_W-1:0] trig_entry(input int unsigned p);
    longint unsigned x, term, q, mag_c, mag_s;
    longint c, s;
    logic [TRIG_W-1:0] rc, rs;
    x    = (64'(p) * TWO_PI_Q28) / POINTS;
    term = 64'd1 << 28;
    c    = 0;
    s    = 0;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      if (k > 0) begin
        q = (term * x) >> 28;
        case (k)
          1: term = q / 1;    2: term = q / 2;    3: term = q / 3;    4: term = q / 4;
          5: term = q / 5;    6: term = q / 6;    7: term = q / 7;    8: term = q / 8;
          9: term = q / 9;    10: term = q / 10;  11: term = q / 11;  12: term = q / 12;
          13: term = q / 13;  14: term = q / 14;  15: term = q / 15;  16: term = q / 16;
          17: term = q / 17;  18: term = q / 18;  19: term = q / 19;  20: term = q / 20;
          21: term = q / 21;  22: term = q / 22;  23: term = q / 23;
          default: term = q;
        endcase
      end
      case (k & 3)
        0: c = c + longint'(term);
        1: s = s + longint'(term);
        2: c = c - longint'(term);
        default: s = s - longint'(term);
      endcase
    end
    mag_c = (c < 0) ? 64'(-c) : 64'(c);
    mag_s = (s < 0) ? 64'(-s) : 64'(s);
    rc = TRIG_W'((mag_c + 64'd8192) >> 14);
    rs = TRIG_W'((mag_s + 64'd8192) >> 14);
    if (c < 0) rc = -rc;
    if (s < 0) rs = -rs;
    return {rc, rs};
  endfunction

  // first half period; the second half mirrors it with sin negated
  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = trig_entry(unsigned'(i));
    end
    return r;
  endfunction

endpackage

/* src/fss_coef_store.sv */
module fss_coef_store
  import fss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [2*COEF_W-1:0]  wr_data_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output logic [2*COEF_W-1:0]  rd_data_o
);

  logic [2*COEF_W-1:0] mem_q [STORE_DEPTH];
  logic [2*COEF_W-1:0] rd_q;

  // entries clear to zero on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_idx_i];
  end

  assign rd_data_o = rd_q;

endmodule

/* src/fss_trig_rom.sv */
module fss_trig_rom
  import fss_pkg::*;
(
  input  logic                      clk_i,
  input  logic [PHASE_W-1:0]        phase_i,
  output logic signed [TRIG_W-1:0]  cos_o,
  output logic signed [TRIG_W-1:0]  sin_o
);

  localparam rom_t TRIG_ROM = build_rom();

  logic                neg;
  logic [ROM_AW-1:0]   addr;
  logic [2*TRIG_W-1:0] word_q;
  logic                neg_q;
  logic signed [TRIG_W-1:0] sin_raw;

  // fold upper half of the period onto the lower half
  assign neg  = phase_i > PHASE_W'(POINTS / 2);
  assign addr = neg ? ROM_AW'(PHASE_W'(0) - phase_i) : ROM_AW'(phase_i);

  always_ff @(posedge clk_i) begin
    word_q <= TRIG_ROM[addr];
    neg_q  <= neg;
  end

  assign cos_o   = word_q[2*TRIG_W-1:TRIG_W];
  assign sin_raw = word_q[TRIG_W-1:0];
  assign sin_o   = neg_q ? -sin_raw : sin_raw;

endmodule

/* src/fss_cmac.sv */
`include "fourier_series_synthesizer_defines.svh"

module fss_cmac
  import fss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctl_t                      ctl_i,
  input  logic [2*COEF_W-1:0]       coef_i,
  input  logic signed [TRIG_W-1:0]  cos_i,
  input  logic signed [TRIG_W-1:0]  sin_i,
  output logic                      pipe_busy_o,
  output logic signed [OUT_W-1:0]   point_x_o,
  output logic signed [OUT_W-1:0]   point_y_o,
  output logic                      point_valid_o
);

  localparam int WIDE_W     = ACC_W + 4;
  localparam int ROUND_HALF = 8192;

  logic v1_q, v2_q;
  logic signed [COEF_W-1:0] cr, ci;
  logic signed [PROD_W-1:0] rc_q, is_q, rs_q, ic_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;
  logic signed [OUT_W-1:0]  x_q, y_q;
  logic                     valid_q;

  // times ten, round off the 14 fraction bits of the q1.14 trig values, saturate to signed 32 bits
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [WIDE_W-1:0] w, v, hi, lo;
    w  = WIDE_W'(a);
    v  = ((w <<< 3) + (w <<< 1) + WIDE_W'(ROUND_HALF)) >>> 14;
    hi = (WIDE_W'(1) <<< (OUT_W - 1)) - WIDE_W'(1);
    lo = -(WIDE_W'(1) <<< (OUT_W - 1));
    if (v > hi) return hi[OUT_W-1:0];
    if (v < lo) return lo[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

  assign cr = coef_i[2*COEF_W-1:COEF_W];
  assign ci = coef_i[COEF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      v1_q    <= ctl_i.issue;
      v2_q    <= v1_q;
      valid_q <= ctl_i.fin;
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    rc_q <= cr * cos_i;
    is_q <= ci * sin_i;
    rs_q <= cr * sin_i;
    ic_q <= ci * cos_i;
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + ACC_W'(rc_q) - ACC_W'(is_q);
      acc_im_q <= acc_im_q + ACC_W'(rs_q) + ACC_W'(ic_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      x_q <= round_sat(acc_re_q);
      y_q <= round_sat(acc_im_q);
    end
  end

  assign pipe_busy_o   = v1_q | v2_q;
  assign point_x_o     = x_q;
  assign point_y_o     = y_q;
  assign point_valid_o = valid_q;

  `FSS_ASSERT_IMP(a_clr_empty, ctl_i.clr, !v1_q && !v2_q, "clear while terms in flight")
  `FSS_ASSERT_NXT(a_fin_strobe, ctl_i.fin, point_valid_o, "finish without result strobe")
  `FSS_ASSERT_NXT(a_single_strobe, point_valid_o, !point_valid_o, "result strobe repeated")

endmodule

/* src/fss_ctrl.sv */
`include "fourier_series_synthesizer_defines.svh"

module fss_ctrl
  import fss_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic signed [HARM_W-1:0] harmonic_i,
  input  logic [T_W-1:0]           sample_index_i,
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_data_i,
  input  logic                     pipe_busy_i,
  output ctl_t                     ctl_o,
  output logic                     load_we_o,
  output logic [IDX_W-1:0]         load_idx_o,
  output logic [IDX_W-1:0]         rd_idx_o,
  output logic [PHASE_W-1:0]       phase_o
);

  localparam logic signed [HARM_W-1:0] K_MAX = HARM_W'(MAX_HARMONIC);
  localparam logic signed [HARM_W-1:0] K_MIN = -K_MAX;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [PHASE_W-1:0]   t_q, t_d;
  logic [HARM_W-1:0]    k_q, k_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic                 in_range;

  assign in_range   = (harmonic_i >= K_MIN) && (harmonic_i <= K_MAX);
  assign load_idx_o = IDX_W'(harmonic_i + K_MAX);
  assign rd_idx_o   = IDX_W'(k_q + HARM_W'(MAX_HARMONIC));
  assign phase_o    = phase_q;
  assign busy       = state_q != ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= CNT_W'(1);
      n_q     <= '0;
      t_q     <= '0;
      k_q     <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cnt_q <= cfg_data_i;
      n_q     <= n_d;
      t_q     <= t_d;
      k_q     <= k_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    t_d       = t_q;
    k_d       = k_q;
    phase_d   = phase_q;
    ctl_o     = '0;
    load_we_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (opcode_i == OP_EVAL) begin
            n_d       = (cnt_q > CNT_W'(MAX_HARMONIC)) ? CNT_W'(MAX_HARMONIC) : cnt_q;
            t_d       = sample_index_i[PHASE_W-1:0];
            // first term is k = -n, phase -(n*t) mod period
            k_d       = HARM_W'(0) - HARM_W'(n_d);
            phase_d   = PHASE_W'(0) - PHASE_W'(n_d * t_d);
            ctl_o.clr = 1'b1;
            state_d   = ST_RUN;
          end else begin
            load_we_o = in_range;
          end
        end
      end
      ST_RUN: begin
        ctl_o.issue = 1'b1;
        if (k_q == HARM_W'(n_q)) begin
          state_d = ST_DRAIN;
        end else begin
          k_d     = k_q + HARM_W'(1);
          phase_d = phase_q + t_q;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          ctl_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `FSS_ASSERT_IMP(a_k_bound, state_q == ST_RUN, ($signed(k_q) <= $signed({1'b0, n_q})) && ($signed(k_q) >= -$signed({1'b0, n_q})), "harmonic index out of range")
  `FSS_ASSERT_IMP(a_phase_step, (state_q == ST_RUN) && $past(state_q == ST_RUN), phase_q == PHASE_W'($past(phase_q) + $past(t_q)), "phase step lost")
  `FSS_ASSERT_NXT(a_eval_start, start && !busy && (opcode_i == OP_EVAL), state_q == ST_RUN, "evaluate not started")

endmodule

/* src/fourier_series_synthesizer.sv */
// an evaluate item steps k from -n to n, then drains the multiply-accumulate pipeline, and its
// result is strobed (n = harmonic count, clamped to 15); busy stays high until then
// the single complex multiply-accumulate unit takes one term per cycle, and a new evaluate item
// is accepted only once busy is low; a load item is written while idle and busy stays low
// the receiver cannot stall: point_valid_o is high for one cycle per evaluate item
// reset (rst_ni low, asynchronous): coefficients clear to zero, harmonic count becomes 1
module fourier_series_synthesizer
  import fss_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command side
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode_i,
  input  logic signed [HARM_W-1:0] harmonic_i,
  input  logic signed [COEF_W-1:0] coef_real_i,
  input  logic signed [COEF_W-1:0] coef_imag_i,
  input  logic [T_W-1:0]           sample_index_i,
  // harmonic count register
  input  logic                     cfg_we_i,
  input  logic [CNT_W-1:0]         cfg_data_i,
  // result side
  output logic signed [OUT_W-1:0]  point_x_o,
  output logic signed [OUT_W-1:0]  point_y_o,
  output logic                     point_valid_o
);

  ctl_t                     ctl;
  logic                     pipe_busy;
  logic                     load_we;
  logic [IDX_W-1:0]         load_idx;
  logic [IDX_W-1:0]         rd_idx;
  logic [PHASE_W-1:0]       phase;
  logic [2*COEF_W-1:0]      coef;
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [TRIG_W-1:0] sin_v;

  // sequencer: walks k from -n to n, one term per cycle, phase stepped by t
  fss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .harmonic_i     (harmonic_i),
    .sample_index_i (sample_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .pipe_busy_i    (pipe_busy),
    .ctl_o          (ctl),
    .load_we_o      (load_we),
    .load_idx_o     (load_idx),
    .rd_idx_o       (rd_idx),
    .phase_o        (phase)
  );

  // coefficient store, real part in the upper half of each word
  fss_coef_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (load_we),
    .wr_idx_i  (load_idx),
    .wr_data_i ({coef_real_i, coef_imag_i}),
    .rd_idx_i  (rd_idx),
    .rd_data_o (coef)
  );

  // half-period cos/sin table, read alongside the coefficient
  fss_trig_rom u_rom (
    .clk_i   (clk_i),
    .phase_i (phase),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // shared complex multiply-accumulate, then scale by ten, round and saturate
  fss_cmac u_cmac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .coef_i        (coef),
    .cos_i         (cos_v),
    .sin_i         (sin_v),
    .pipe_busy_o   (pipe_busy),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .point_valid_o (point_valid_o)
  );

endmodule
